/* rtl/mf3_pkg.sv */
// mf3_pkg: shared types, constants and compare helpers for the 3x3 median filter
// no dependencies; imported by the interfaces and every rtl module of the block
`default_nettype none

package mf3_pkg;

   localparam int PIX_W            = 8;
   localparam int CSR_W            = 12;
   localparam int MAX_LINE_DEFAULT = 2048;
   localparam int LINE_WIDTH_RESET = 640;
   localparam int MIN_LINE         = 3;
   localparam int WIN_TAPS         = 9;
   localparam int QUEUE_DEPTH      = 4;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [1:0] row_type;

   // row counter saturates here; the window is complete from this row on
   localparam row_type ROW_LAST = 2'd2;

   typedef struct packed {
      pix_type [WIN_TAPS-1:0] taps;
      logic                   valid;
   } window_type;

   typedef struct packed {
      logic    take;
      pix_type pixel;
      logic    frame_start;
   } front_in_type;

   typedef struct packed {
      logic push;
      logic clearing;
   } front_status_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      pix_type lo;
      pix_type mid;
      pix_type hi;
   } trio_type;

   function automatic row_type row_step(input row_type r);
      return (r == ROW_LAST) ? r : row_type'(r + 2'd1);
   endfunction

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic pix_type min3(input pix_type a, input pix_type b, input pix_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic pix_type max3(input pix_type a, input pix_type b, input pix_type c);
      return max2(max2(a, b), c);
   endfunction

   // three compare-exchange steps
   function automatic trio_type sort3(input pix_type a, input pix_type b, input pix_type c);
      pix_type  lo1;
      pix_type  hi1;
      pix_type  hi2;
      trio_type t;
      lo1   = min2(a, b);
      hi1   = max2(a, b);
      hi2   = max2(hi1, c);
      t.hi  = hi2;
      t.lo  = min2(lo1, min2(hi1, c));
      t.mid = max2(lo1, min2(hi1, c));
      return t;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      trio_type t;
      t = sort3(a, b, c);
      return t.mid;
   endfunction

endpackage

`default_nettype wire

/* rtl/mf3_if.sv */
// mf3_req_if / mf3_rsp_if: valid-ready channels for pixels in and medians out
// depends on mf3_pkg for the pixel type
`default_nettype none

interface mf3_req_if import mf3_pkg::*; ;
   logic    valid;
   logic    ready;
   pix_type pixel;
   logic    frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface mf3_rsp_if import mf3_pkg::*; ;
   logic    valid;
   logic    ready;
   pix_type median_value;
   logic    window_valid;

   modport source (output valid, output median_value, output window_valid, input ready);
   modport sink   (input valid, input median_value, input window_valid, output ready);
endinterface

`default_nettype wire

/* rtl/mf3_front.sv */
// mf3_front: line width register, column/row tracking, two line stores and the
// 3x3 window; pushes one window per accepted pixel. depends on mf3_pkg
`default_nettype none

module mf3_front import mf3_pkg::*; #(
   parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  front_in_type         fin,
   output front_status_type     stat,
   output window_type           entry
);

   localparam int AW     = $clog2(MAX_LINE);
   localparam int WW     = $clog2(MAX_LINE + 1);
   localparam int CW     = (WW > CSR_W) ? WW : CSR_W;
   localparam int RstEff = (LINE_WIDTH_RESET > MAX_LINE) ? MAX_LINE : LINE_WIDTH_RESET;

   // effective (clamped) line width
   logic [WW-1:0] eff_ff, eff_in;
   logic [CW-1:0] wdata_ext;

   logic [AW-1:0] col_ff, col_in;
   row_type       row_ff, row_in;

   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   logic          s1_v_ff;
   pix_type       s1_px_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          s1_ok_ff;
   pix_type       rd_up_ff, rd_mid_ff;
   logic          byp_ff;
   pix_type       byp_up_ff, byp_mid_ff;

   pix_type       upper_mem [MAX_LINE];
   pix_type       middle_mem [MAX_LINE];

   pix_type [WIN_TAPS-1:0] win_ff, win_in;

   logic [WW-1:0] c0, c1, nxt;
   row_type       r0, r1;
   logic [AW-1:0] addr;
   logic          win_ok;
   logic          hit;
   pix_type       up_eff, mid_eff;

   always_comb begin
      wdata_ext = CW'(csr_wdata);
      if (wdata_ext < CW'(MIN_LINE)) begin
         eff_in = WW'(MIN_LINE);
      end else if (wdata_ext > CW'(MAX_LINE)) begin
         eff_in = WW'(MAX_LINE);
      end else begin
         eff_in = wdata_ext[WW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_ff <= WW'(RstEff);
      end else if (csr_we) begin
         eff_ff <= eff_in;
      end
   end

   // position of the incoming pixel, then the position that follows it
   always_comb begin
      c0 = fin.frame_start ? '0 : WW'(col_ff);
      r0 = fin.frame_start ? '0 : row_ff;
      if (c0 >= eff_ff) begin
         c1 = '0;
         r1 = row_step(r0);
      end else begin
         c1 = c0;
         r1 = r0;
      end
      addr   = c1[AW-1:0];
      win_ok = (r1 == ROW_LAST) && (c1 >= WW'(2));
      nxt    = c1 + WW'(1);
      if (nxt >= eff_ff) begin
         col_in = '0;
         row_in = row_step(r1);
      end else begin
         col_in = nxt[AW-1:0];
         row_in = r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (fin.take) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // zero both line stores after reset, one address a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(MAX_LINE - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // a write still pending in stage one to the same column is forwarded
   assign hit     = s1_v_ff && (s1_addr_ff == addr);
   assign up_eff  = byp_ff ? byp_up_ff : rd_up_ff;
   assign mid_eff = byp_ff ? byp_mid_ff : rd_mid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         byp_ff  <= 1'b0;
      end else begin
         s1_v_ff <= fin.take;
         if (fin.take) begin
            byp_ff <= hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin.take) begin
         s1_px_ff   <= fin.pixel;
         s1_addr_ff <= addr;
         s1_ok_ff   <= win_ok;
         byp_up_ff  <= mid_eff;
         byp_mid_ff <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin.take) begin
         rd_up_ff  <= upper_mem[addr];
         rd_mid_ff <= middle_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         upper_mem[clr_addr_ff]  <= '0;
         middle_mem[clr_addr_ff] <= '0;
      end else if (s1_v_ff) begin
         upper_mem[s1_addr_ff]  <= mid_eff;
         middle_mem[s1_addr_ff] <= s1_px_ff;
      end
   end

   // shift left by one column, new column enters on the right
   always_comb begin
      win_in = win_ff;
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = up_eff;
      win_in[5] = mid_eff;
      win_in[8] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         win_ff <= win_in;
      end
   end

   assign entry.taps    = win_in;
   assign entry.valid   = s1_ok_ff;
   assign stat.push     = s1_v_ff;
   assign stat.clearing = clr_busy_ff;

endmodule

`default_nettype wire

/* rtl/mf3_queue.sv */
// mf3_queue: short window queue between the front and the median back end
// depends on mf3_pkg for the window type
`default_nettype none

module mf3_queue import mf3_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  window_type       push_data,
   input  logic             pop,
   output window_type       pop_data,
   output queue_status_type qstat
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   window_type    slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data    = slot_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == NW'(DEPTH));

endmodule

`default_nettype wire

/* rtl/mf3_back.sv */
// mf3_back: three-stage median-of-nine pipeline (column sort, row reduce, final
// median) ending in the output register. depends on mf3_pkg and mf3_rsp_if
`default_nettype none

module mf3_back import mf3_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type qstat,
   input  window_type       qdata,
   output logic             pop,
   mf3_rsp_if.source        rsp
);

   logic     en;
   logic     b1_v_ff, b2_v_ff, b3_v_ff;
   logic     b1_ok_ff, b2_ok_ff;
   trio_type b1_col_ff [3];
   pix_type  b2_lo_ff, b2_mid_ff, b2_hi_ff;
   pix_type  b3_med_ff;
   logic     b3_wv_ff;

   // whole pipeline moves unless the output register holds an untaken result
   assign en  = !b3_v_ff || rsp.ready;
   assign pop = en && !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         b3_v_ff <= 1'b0;
      end else if (en) begin
         b1_v_ff <= pop;
         b2_v_ff <= b1_v_ff;
         b3_v_ff <= b2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            b1_col_ff[k] <= sort3(qdata.taps[k], qdata.taps[3 + k], qdata.taps[6 + k]);
         end
         b1_ok_ff  <= qdata.valid;
         b2_lo_ff  <= max3(b1_col_ff[0].lo, b1_col_ff[1].lo, b1_col_ff[2].lo);
         b2_mid_ff <= med3(b1_col_ff[0].mid, b1_col_ff[1].mid, b1_col_ff[2].mid);
         b2_hi_ff  <= min3(b1_col_ff[0].hi, b1_col_ff[1].hi, b1_col_ff[2].hi);
         b2_ok_ff  <= b1_ok_ff;
         b3_med_ff <= b2_ok_ff ? med3(b2_lo_ff, b2_mid_ff, b2_hi_ff) : '0;
         b3_wv_ff  <= b2_ok_ff;
      end
   end

   assign rsp.valid        = b3_v_ff;
   assign rsp.median_value = b3_med_ff;
   assign rsp.window_valid = b3_wv_ff;

endmodule

`default_nettype wire

/* rtl/median_filter_3x3.sv */
// median_filter_3x3: 3x3 median over a raster pixel stream, one pixel per clock while
// req.ready is high (low while clearing or when all queue credit is used); a transferred
// pixel passes the registered line store read, window queue and 3-stage median pipeline.
// synchronous active-high reset; line width returns to 640 (clamped to MAX_LINE), then
// both line stores are zeroed with req.ready low (csr writes still taken).
`default_nettype none

module median_filter_3x3 import mf3_pkg::*; #(
   parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   mf3_req_if.sink          req,
   mf3_rsp_if.source        rsp,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int CRW = $clog2(QUEUE_DEPTH + 1);

   front_in_type     fin;
   front_status_type fstat;
   window_type       push_data, pop_data;
   queue_status_type qstat;
   logic             pop;
   logic             take;
   logic [CRW-1:0]   credit_ff, credit_in;

   // items transferred in but not yet pulled from the queue
   always_comb begin
      credit_in = credit_ff;
      if (take && !pop) begin
         credit_in = credit_ff + CRW'(1);
      end else if (pop && !take) begin
         credit_in = credit_ff - CRW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   assign req.ready       = !fstat.clearing && (credit_ff < CRW'(QUEUE_DEPTH));
   assign take            = req.valid && req.ready;
   assign fin.take        = take;
   assign fin.pixel       = req.pixel;
   assign fin.frame_start = req.frame_start;

   mf3_front #(
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fin       (fin),
      .stat      (fstat),
      .entry     (push_data)
   );

   mf3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fstat.push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   mf3_back u_back (
      .clock (clock),
      .reset (reset),
      .qstat (qstat),
      .qdata (pop_data),
      .pop   (pop),
      .rsp   (rsp)
   );

`ifndef NO_ASSERTIONS
   a_push_room : assert property (@(posedge clock) disable iff (reset)
      fstat.push |-> !qstat.full)
      else $error("window pushed into a full queue");

   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRW'(QUEUE_DEPTH))
      else $error("more items in flight than queue slots");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.window_valid |-> rsp.median_value == '0)
      else $error("nonzero median for an incomplete window");
`endif

endmodule

`default_nettype wire
